[hw/rtl/clt_pkg.sv]
// Shared types, codes and WTF-8 encoding helpers for the command line tokenizer.
// No dependencies; the front, queue, back and top level files refer to this package.
package clt_pkg;

  // Work queue between the front and the back part.
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

  // Input operation codes.
  localparam logic OP_UNIT  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Character codes that steer the parser.
  localparam logic [20:0] CH_QUOTE = 21'h00022;
  localparam logic [20:0] CH_BSL   = 21'h0005c;
  localparam logic [20:0] CH_SPACE = 21'h00020;
  localparam logic [20:0] CH_TAB   = 21'h00009;
  localparam logic [5:0]  SUR_HIGH = 6'h36;
  localparam logic [5:0]  SUR_LOW  = 6'h37;

  // Parser state.
  typedef enum logic [3:0] {
    ST_BETWEEN = 4'd0,
    ST_UNQ     = 4'd1,
    ST_QUO     = 4'd2,
    ST_BS_UNQ  = 4'd3,
    ST_BS_QUO  = 4'd4,
    ST_CLOSE   = 4'd5,
    ST_FIRST   = 4'd6,
    ST_FIRST_U = 4'd7,
    ST_FIRST_Q = 4'd8
  } parse_state_t;

  // Result kinds on the output channel.
  typedef enum logic [1:0] {
    RK_BYTE     = 2'd0,
    RK_ARG_END  = 2'd1,
    RK_RUN      = 2'd2,
    RK_LINE_END = 2'd3
  } result_kind_t;

  // What one character slot of a work descriptor emits.
  typedef enum logic [1:0] {
    SK_NONE = 2'd0,
    SK_CP   = 2'd1,
    SK_END  = 2'd2
  } slot_kind_t;

  // Result slots of a work descriptor, in emission order.
  typedef enum logic [1:0] {
    SL_RUN  = 2'd0,
    SL_A    = 2'd1,
    SL_B    = 2'd2,
    SL_LINE = 2'd3
  } slot_t;

  // All results of one accepted request, in compact form.
  typedef struct packed {
    logic         run_v;
    logic [14:0]  run_len;
    slot_kind_t   a_kind;
    logic [20:0]  a_cp;
    slot_kind_t   b_kind;
    logic [20:0]  b_cp;
    logic         line_v;
    logic [14:0]  count;
  } work_t;

  // Number of WTF-8 bytes of a code point, minus one.
  function automatic logic [1:0] cp_len(input logic [20:0] cp);
    logic [1:0] n;
    if (cp < 21'h80) begin
      n = 2'd0;
    end else if (cp < 21'h800) begin
      n = 2'd1;
    end else if (cp < 21'h10000) begin
      n = 2'd2;
    end else begin
      n = 2'd3;
    end
    return n;
  endfunction

  // Byte number idx of the WTF-8 form of a code point.
  function automatic logic [7:0] cp_byte(input logic [20:0] cp, input logic [1:0] idx);
    logic [7:0] b;
    case ({cp_len(cp), idx})
      4'b00_00: b = cp[7:0];
      4'b01_00: b = {3'b110, cp[10:6]};
      4'b01_01: b = {2'b10, cp[5:0]};
      4'b10_00: b = {4'b1110, cp[15:12]};
      4'b10_01: b = {2'b10, cp[11:6]};
      4'b10_10: b = {2'b10, cp[5:0]};
      4'b11_00: b = {5'b11110, cp[20:18]};
      4'b11_01: b = {2'b10, cp[17:12]};
      4'b11_10: b = {2'b10, cp[11:6]};
      4'b11_11: b = {2'b10, cp[5:0]};
      default:  b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

[hw/rtl/clt_if.sv]
// Valid/ready channel interfaces for the command line tokenizer.
// Input channel carries code units; output channel carries result items.
interface clt_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] code_unit;

  modport source (output valid, output operation, output code_unit, input ready);
  modport sink   (input valid, input operation, input code_unit, output ready);
endinterface

interface clt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  byte_value;
  logic [14:0] run_length;
  logic [14:0] argument_count;
  logic        last;

  modport source (output valid, output kind, output byte_value, output run_length,
                  output argument_count, output last, input ready);
  modport sink   (input valid, input kind, input byte_value, input run_length,
                  input argument_count, input last, output ready);
endinterface

[hw/rtl/clt_front.sv]
// Front part: accepts requests, runs the argument parser and builds work descriptors.
// Depends on clt_pkg and clt_in_if.
module clt_front #(
  parameter int unsigned MAX_RUN  = 32767,
  parameter int unsigned MAX_ARGS = 16384
) (
  input  logic          clk,
  input  logic          rst_n,
  clt_in_if.sink        in_ch,
  input  logic          q_full,
  output logic          push,
  output clt_pkg::work_t push_data
);

  localparam int unsigned RUN_W  = $clog2(MAX_RUN + 1);
  localparam int unsigned ARGS_W = $clog2(MAX_ARGS + 1);

  typedef struct packed {
    clt_pkg::parse_state_t st;
    logic [RUN_W-1:0]      run;
    logic [ARGS_W-1:0]     args;
    logic                  run_v;
    logic [14:0]           run_len;
    clt_pkg::slot_kind_t   emit;
  } step_t;

  // One parser step on one code point.
  function automatic step_t step_char(input step_t cur, input logic [20:0] c);
    step_t r;
    logic  blank;
    logic  quote;
    logic  bslash;
    logic  fin;
    logic [RUN_W-1:0] half;
    r         = cur;
    r.run_v   = 1'b0;
    r.run_len = '0;
    r.emit    = clt_pkg::SK_NONE;
    blank     = (c == clt_pkg::CH_SPACE) || (c == clt_pkg::CH_TAB);
    quote     = (c == clt_pkg::CH_QUOTE);
    bslash    = (c == clt_pkg::CH_BSL);
    half      = cur.run >> 1;
    fin       = 1'b0;
    // Backslash runs and the state after a closing quote resolve first.
    if (cur.st == clt_pkg::ST_BS_UNQ || cur.st == clt_pkg::ST_BS_QUO) begin
      if (bslash) begin
        if (cur.run < RUN_W'(MAX_RUN)) begin
          r.run = cur.run + 1'b1;
        end
        fin = 1'b1;
      end else begin
        r.st  = (cur.st == clt_pkg::ST_BS_UNQ) ? clt_pkg::ST_UNQ : clt_pkg::ST_QUO;
        r.run = '0;
        if (quote) begin
          r.run_v   = (half != '0);
          r.run_len = 15'(half);
          if (cur.run[0]) begin
            r.emit = clt_pkg::SK_CP;
            fin    = 1'b1;
          end
        end else begin
          r.run_v   = (cur.run != '0);
          r.run_len = 15'(cur.run);
        end
      end
    end else if (cur.st == clt_pkg::ST_CLOSE) begin
      r.st = clt_pkg::ST_UNQ;
      if (quote) begin
        r.emit = clt_pkg::SK_CP;
        fin    = 1'b1;
      end
    end
    if (!fin) begin
      unique case (r.st)
        clt_pkg::ST_UNQ: begin
          if (blank) begin
            r.emit = clt_pkg::SK_END;
            r.st   = clt_pkg::ST_BETWEEN;
          end else if (quote) begin
            r.st = clt_pkg::ST_QUO;
          end else if (bslash) begin
            r.run = RUN_W'(1);
            r.st  = clt_pkg::ST_BS_UNQ;
          end else begin
            r.emit = clt_pkg::SK_CP;
          end
        end
        clt_pkg::ST_QUO: begin
          if (quote) begin
            r.st = clt_pkg::ST_CLOSE;
          end else if (bslash) begin
            r.run = RUN_W'(1);
            r.st  = clt_pkg::ST_BS_QUO;
          end else begin
            r.emit = clt_pkg::SK_CP;
          end
        end
        clt_pkg::ST_FIRST: begin
          if (blank) begin
            r.emit = clt_pkg::SK_END;
            r.st   = clt_pkg::ST_BETWEEN;
          end else if (quote) begin
            r.st = clt_pkg::ST_FIRST_Q;
          end else begin
            r.st   = clt_pkg::ST_FIRST_U;
            r.emit = clt_pkg::SK_CP;
          end
        end
        clt_pkg::ST_FIRST_U: begin
          if (blank) begin
            r.emit = clt_pkg::SK_END;
            r.st   = clt_pkg::ST_BETWEEN;
          end else begin
            r.emit = clt_pkg::SK_CP;
          end
        end
        clt_pkg::ST_FIRST_Q: begin
          if (quote) begin
            r.emit = clt_pkg::SK_END;
            r.st   = clt_pkg::ST_BETWEEN;
          end else begin
            r.emit = clt_pkg::SK_CP;
          end
        end
        clt_pkg::ST_BS_UNQ, clt_pkg::ST_BS_QUO, clt_pkg::ST_CLOSE: begin
          r.st = r.st;
        end
        default: begin
          r.st = clt_pkg::ST_BETWEEN;
          if (!blank) begin
            if (cur.args < ARGS_W'(MAX_ARGS)) begin
              r.args = cur.args + 1'b1;
            end
            if (quote) begin
              r.st = clt_pkg::ST_QUO;
            end else if (bslash) begin
              r.run = RUN_W'(1);
              r.st  = clt_pkg::ST_BS_UNQ;
            end else begin
              r.st   = clt_pkg::ST_UNQ;
              r.emit = clt_pkg::SK_CP;
            end
          end
        end
      endcase
    end
    return r;
  endfunction

  clt_pkg::parse_state_t state_r, state_nxt;
  logic [RUN_W-1:0]      run_r, run_nxt;
  logic [ARGS_W-1:0]     args_r, args_nxt;
  logic [9:0]            held_r, held_nxt;
  logic                  held_v_r, held_v_nxt;

  logic        accept;
  logic        is_flush;
  logic        unit_nz;
  logic        c_high;
  logic        c_low;
  logic [20:0] cu21;
  logic [20:0] held_cp;
  logic [20:0] joined_cp;
  logic [20:0] p1_c;
  logic        p1_act;
  logic        p2_act;
  step_t       cur;
  step_t       s1;
  step_t       p1;
  step_t       p2;
  step_t       s_end;
  logic        fl_run_v;
  logic        fl_end;
  clt_pkg::parse_state_t fl_st;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_flush    = (in_ch.operation == clt_pkg::OP_FLUSH);
  assign unit_nz     = (in_ch.code_unit != 16'h0000);
  assign c_high      = (in_ch.code_unit[15:10] == clt_pkg::SUR_HIGH);
  assign c_low       = (in_ch.code_unit[15:10] == clt_pkg::SUR_LOW);
  assign cu21        = {5'b0, in_ch.code_unit};
  assign held_cp     = {5'b0, clt_pkg::SUR_HIGH, held_r};
  assign joined_cp   = 21'h10000 + {1'b0, held_r, in_ch.code_unit[9:0]};

  // Select which code points this request runs through the parser.
  always_comb begin
    cur = '{st: state_r, run: run_r, args: args_r, run_v: 1'b0, run_len: '0,
            emit: clt_pkg::SK_NONE};
    if (is_flush) begin
      p1_c   = held_cp;
      p1_act = held_v_r;
      p2_act = 1'b0;
    end else begin
      p1_c   = (held_v_r && c_low) ? joined_cp : (held_v_r ? held_cp : cu21);
      p1_act = unit_nz && (held_v_r || !c_high);
      p2_act = unit_nz && held_v_r && !c_low && !c_high;
    end
    p1    = step_char(cur, p1_c);
    s1    = p1_act ? p1 : cur;
    p2    = step_char(s1, cu21);
    s_end = p2_act ? p2 : s1;
    // Flush tail: pending backslashes, then the open argument is closed.
    fl_run_v = (s1.st == clt_pkg::ST_BS_UNQ || s1.st == clt_pkg::ST_BS_QUO) &&
               (s1.run != '0);
    if (s1.st == clt_pkg::ST_BS_UNQ) begin
      fl_st = clt_pkg::ST_UNQ;
    end else if (s1.st == clt_pkg::ST_BS_QUO) begin
      fl_st = clt_pkg::ST_QUO;
    end else begin
      fl_st = s1.st;
    end
    fl_end = (fl_st != clt_pkg::ST_BETWEEN);
  end

  // Next state of the parser registers.
  always_comb begin
    state_nxt  = state_r;
    run_nxt    = run_r;
    args_nxt   = args_r;
    held_nxt   = held_r;
    held_v_nxt = held_v_r;
    if (accept) begin
      if (is_flush) begin
        state_nxt  = clt_pkg::ST_FIRST;
        run_nxt    = '0;
        args_nxt   = ARGS_W'(1);
        held_nxt   = '0;
        held_v_nxt = 1'b0;
      end else if (unit_nz) begin
        state_nxt = s_end.st;
        run_nxt   = s_end.run;
        args_nxt  = s_end.args;
        if (c_high && !(held_v_r && c_low)) begin
          held_nxt   = in_ch.code_unit[9:0];
          held_v_nxt = 1'b1;
        end else begin
          held_v_nxt = 1'b0;
        end
      end
    end
  end

  // Work descriptor for the back part.
  always_comb begin
    push_data.run_v   = (p1_act && p1.run_v) || (is_flush && fl_run_v);
    push_data.run_len = (is_flush && fl_run_v) ? 15'(s1.run) : p1.run_len;
    push_data.a_kind  = p1_act ? p1.emit : clt_pkg::SK_NONE;
    push_data.a_cp    = p1_c;
    if (is_flush) begin
      push_data.b_kind = fl_end ? clt_pkg::SK_END : clt_pkg::SK_NONE;
    end else begin
      push_data.b_kind = p2_act ? p2.emit : clt_pkg::SK_NONE;
    end
    push_data.b_cp   = cu21;
    push_data.line_v = is_flush;
    push_data.count  = 15'(s1.args);
    push = accept && (push_data.run_v || push_data.line_v ||
                      push_data.a_kind != clt_pkg::SK_NONE ||
                      push_data.b_kind != clt_pkg::SK_NONE);
  end

  // Parser registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= clt_pkg::ST_FIRST;
      run_r    <= '0;
      args_r   <= ARGS_W'(1);
      held_r   <= '0;
      held_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      run_r    <= run_nxt;
      args_r   <= args_nxt;
      held_r   <= held_nxt;
      held_v_r <= held_v_nxt;
    end
  end

  // A flush returns the whole parser to its start state.
  a_flush_resets: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_flush |=> state_r == clt_pkg::ST_FIRST && !held_v_r &&
                           args_r == ARGS_W'(1) && run_r == '0)
    else $error("parser not back at start after flush");

  // A backslash count is held exactly while the parser sits in a backslash state.
  a_run_in_bs_state: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == clt_pkg::ST_BS_UNQ || state_r == clt_pkg::ST_BS_QUO) == (run_r != '0))
    else $error("backslash count out of step with parser state");

endmodule

[hw/rtl/clt_queue.sv]
// Short work queue between the front and back parts of the tokenizer.
// Depends on clt_pkg for the descriptor type and the depth.
module clt_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  clt_pkg::work_t push_data,
  output logic           full,
  output logic           head_v,
  output clt_pkg::work_t head,
  input  logic           pop
);

  clt_pkg::work_t               mem_r [clt_pkg::Q_DEPTH];
  logic [clt_pkg::Q_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [clt_pkg::Q_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [clt_pkg::Q_CW-1:0]     count_r, count_nxt;

  assign full   = (count_r == clt_pkg::Q_CW'(clt_pkg::Q_DEPTH));
  assign head_v = (count_r != '0);
  assign head   = mem_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + {{(clt_pkg::Q_CW-1){1'b0}}, push} -
                 {{(clt_pkg::Q_CW-1){1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Descriptor storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // The queue is never written when full nor read when empty.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full) && !(pop && !head_v))
    else $error("work queue overflow or underflow");

endmodule

[hw/rtl/clt_back.sv]
// Back part: walks each work descriptor; one result per cycle while out_ch is ready.
// Depends on clt_pkg (types, WTF-8 helpers) and clt_out_if.
module clt_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_v,
  input  clt_pkg::work_t head,
  output logic           pop,
  clt_out_if.source      out_ch
);

  logic [2:0]  done_r, done_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic        out_v_r, out_v_nxt;
  clt_pkg::result_kind_t kind_r;
  logic [7:0]  byte_r;
  logic [14:0] run_len_r;
  logic [14:0] count_r;
  logic        last_r;

  logic        pend_run;
  logic        pend_a;
  logic        pend_b;
  logic        fire;
  clt_pkg::slot_t        sel;
  clt_pkg::slot_kind_t   sk;
  logic [20:0] cp;
  clt_pkg::result_kind_t res_kind;
  logic [7:0]  res_byte;
  logic [14:0] res_run;
  logic [14:0] res_count;
  logic        slot_done;
  logic        later;
  logic        is_last;

  assign pend_run = head.run_v && !done_r[0];
  assign pend_a   = (head.a_kind != clt_pkg::SK_NONE) && !done_r[1];
  assign pend_b   = (head.b_kind != clt_pkg::SK_NONE) && !done_r[2];
  assign fire     = head_v && (!out_v_r || out_ch.ready);
  assign pop      = fire && is_last;

  // Pick the next result of the descriptor at the head of the queue.
  always_comb begin
    res_kind  = clt_pkg::RK_LINE_END;
    res_byte  = 8'h00;
    res_run   = '0;
    res_count = '0;
    slot_done = 1'b1;
    later     = 1'b0;
    sel       = clt_pkg::SL_LINE;
    sk        = clt_pkg::SK_NONE;
    cp        = head.a_cp;
    if (pend_run) begin
      sel   = clt_pkg::SL_RUN;
      later = pend_a || pend_b || head.line_v;
    end else if (pend_a) begin
      sel   = clt_pkg::SL_A;
      sk    = head.a_kind;
      later = pend_b || head.line_v;
    end else if (pend_b) begin
      sel   = clt_pkg::SL_B;
      sk    = head.b_kind;
      cp    = head.b_cp;
      later = head.line_v;
    end
    unique case (sel)
      clt_pkg::SL_RUN: begin
        res_kind = clt_pkg::RK_RUN;
        res_run  = head.run_len;
      end
      clt_pkg::SL_A, clt_pkg::SL_B: begin
        if (sk == clt_pkg::SK_CP) begin
          res_kind  = clt_pkg::RK_BYTE;
          res_byte  = clt_pkg::cp_byte(cp, idx_r);
          slot_done = (idx_r == clt_pkg::cp_len(cp));
        end else begin
          res_kind = clt_pkg::RK_ARG_END;
        end
      end
      default: begin
        res_count = head.count;
      end
    endcase
    is_last = slot_done && !later;
  end

  // Progress through the descriptor and the output register.
  always_comb begin
    done_nxt  = done_r;
    idx_nxt   = idx_r;
    out_v_nxt = out_v_r;
    if (fire) begin
      out_v_nxt = 1'b1;
      if (is_last) begin
        done_nxt = '0;
        idx_nxt  = '0;
      end else if (slot_done) begin
        idx_nxt = '0;
        case (sel)
          clt_pkg::SL_RUN: done_nxt[0] = 1'b1;
          clt_pkg::SL_A:   done_nxt[1] = 1'b1;
          clt_pkg::SL_B:   done_nxt[2] = 1'b1;
          default:         done_nxt    = done_r;
        endcase
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r  <= '0;
      idx_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      done_r  <= done_nxt;
      idx_r   <= idx_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (fire) begin
      kind_r    <= res_kind;
      byte_r    <= res_byte;
      run_len_r <= res_run;
      count_r   <= res_count;
      last_r    <= is_last;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.kind           = kind_r;
  assign out_ch.byte_value     = byte_r;
  assign out_ch.run_length     = run_len_r;
  assign out_ch.argument_count = count_r;
  assign out_ch.last           = last_r;

  // A descriptor at the head always has a result left to send.
  a_head_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    head_v |-> (pend_run || pend_a || pend_b || head.line_v))
    else $error("empty work descriptor at queue head");

  // The byte index only moves inside a code point of up to four bytes.
  a_idx_only_in_cp: assert property (@(posedge clk) disable iff (!rst_n)
    head_v && idx_r != '0 |-> sk == clt_pkg::SK_CP && idx_r <= clt_pkg::cp_len(cp))
    else $error("byte index outside a code point");

endmodule

[hw/rtl/command_line_tokenizer_wtf8_unit.sv]
// Top level of the command line tokenizer: front parser, work queue and result sender.
// Depends on clt_pkg, clt_if, clt_front, clt_queue and clt_back.
//
//  channel | dir | handshake     | payload
//  in_ch   | in  | valid / ready | operation, code_unit
//  out_ch  | out | valid / ready | kind, byte_value, run_length, argument_count, last
//
// A request is parsed in the cycle it is accepted; the front takes one request per cycle
// while the four-entry work queue has room.
// The back sends one result per cycle while out_ch is ready. An ASCII unit gives up to
// two results, a unit that resolves a held surrogate up to seven.
// Requests that give no result (zero unit, held high surrogate) push nothing to the queue.
// Synchronous active-low reset clears the parser, queue and output valid; no clearing pass.
// A stall on out_ch fills the queue and then drops in_ch.ready.
module command_line_tokenizer_wtf8_unit #(
  parameter int unsigned MAX_RUN  = 32767,
  parameter int unsigned MAX_ARGS = 16384
) (
  input  logic       clk,
  input  logic       rst_n,
  clt_in_if.sink     in_ch,
  clt_out_if.source  out_ch
);

  logic           push;
  clt_pkg::work_t push_data;
  logic           q_full;
  logic           head_v;
  clt_pkg::work_t head;
  logic           pop;

  // Parser.
  clt_front #(
    .MAX_RUN  (MAX_RUN),
    .MAX_ARGS (MAX_ARGS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // Work queue.
  clt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .head_v    (head_v),
    .head      (head),
    .pop       (pop)
  );

  // Result sender.
  clt_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head_v (head_v),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
